### rtl/bmp_rle_pixel_decoder_macros.svh
// ----------------------------------------------------------------------------
// BMP RLE pixel decoder assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BMP_RLE_PIXEL_DECODER_MACROS_SVH
`define BMP_RLE_PIXEL_DECODER_MACROS_SVH

`ifndef SYNTH
// Check prop on every rising edge outside reset.
`define BMPRLE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bmp_rle_pixel_decoder: assertion failed");
// Check that pre at one edge gives post at the next edge.
`define BMPRLE_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bmp_rle_pixel_decoder: assertion failed");
`else
`define BMPRLE_ASSERT(lbl, clk, rst_n, prop)
`define BMPRLE_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

### rtl/bmprle_pkg.sv
// ----------------------------------------------------------------------------
// BMP RLE pixel decoder package
// Shared widths, types, escape codes, parse phases and register indexes.
// ----------------------------------------------------------------------------
package bmprle_pkg;

  // Width of the internal row and column counters.
  localparam int COORD_BITS = 16;
  // Width of the span coordinate fields on the result channel.
  localparam int SPAN_W     = 16;
  localparam int ROW_EXT_W  = COORD_BITS + 2;
  localparam int COL_EXT_W  = COORD_BITS + 1;
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;

  typedef logic [7:0]                   byte_t;
  typedef logic signed [SPAN_W-1:0]     span_row_t;
  typedef logic [SPAN_W-1:0]            span_col_t;
  typedef logic signed [COORD_BITS-1:0] row_t;
  typedef logic [COORD_BITS-1:0]        col_t;
  typedef logic signed [ROW_EXT_W-1:0]  rowx_t;
  typedef logic [COL_EXT_W-1:0]         colx_t;

  localparam rowx_t ROW_HI = ROW_EXT_W'((longint'(1) <<< (COORD_BITS - 1)) - 1);
  localparam rowx_t ROW_LO = ROW_EXT_W'(-(longint'(1) <<< (COORD_BITS - 1)));
  localparam colx_t COL_HI = COL_EXT_W'((longint'(1) <<< COORD_BITS) - 1);

  // Escape codes in the second byte of a zero-count token.
  localparam byte_t ESC_EOL   = 8'h00;
  localparam byte_t ESC_EOB   = 8'h01;
  localparam byte_t ESC_DELTA = 8'h02;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_WIDTH     = 3'd1,
    REG_HEIGHT    = 3'd2,
    REG_START_ROW = 3'd3,
    REG_DESCEND   = 3'd4
  } reg_idx_e;

  typedef enum logic [6:0] {
    PH_COUNT   = 7'b0000001,
    PH_SECOND  = 7'b0000010,
    PH_DELTA_X = 7'b0000100,
    PH_DELTA_Y = 7'b0001000,
    PH_ABS     = 7'b0010000,
    PH_PAD     = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_e;

endpackage

### rtl/bmprle_ifs.sv
// ----------------------------------------------------------------------------
// BMP RLE pixel decoder channels
// Valid/ready byte channel and span result channel.
// ----------------------------------------------------------------------------
interface bmprle_in_if;
  logic                valid;
  logic                ready;
  bmprle_pkg::byte_t   data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface bmprle_out_if;
  logic                  valid;
  logic                  ready;
  bmprle_pkg::span_row_t span_row;
  bmprle_pkg::span_col_t span_col;
  bmprle_pkg::byte_t     span_length;
  bmprle_pkg::byte_t     color_first;
  bmprle_pkg::byte_t     color_second;
  logic                  out_of_bounds;
  logic                  end_of_image;

  modport source (output valid, output span_row, output span_col, output span_length,
                  output color_first, output color_second, output out_of_bounds,
                  output end_of_image, input ready);
  modport sink   (input valid, input span_row, input span_col, input span_length,
                  input color_first, input color_second, input out_of_bounds,
                  input end_of_image, output ready);
endinterface

### rtl/bmp_rle_pixel_decoder.sv
// A span appears in the result register in the cycle after its byte is accepted.
// Throughput: one compressed byte per cycle; the parse state updates in the accept cycle.
// The result register frees itself in the cycle it is taken, so a byte is taken every cycle
// unless a span is waiting and the sink stalls.
// Reset: the configuration registers take their defaults and parsing restarts at start_row, column 0;
// a write of start_row restarts parsing as well.
// ----------------------------------------------------------------------------
// BMP RLE pixel decoder
// Parses RLE8/RLE4 byte streams into pixel spans with saturating coordinates.
// ----------------------------------------------------------------------------
`include "bmp_rle_pixel_decoder_macros.svh"

module bmp_rle_pixel_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bmprle_in_if.sink                     data_i,
  bmprle_out_if.source                  span_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmprle_pkg::CFG_AW-1:0] paddr,
  input  logic [bmprle_pkg::CFG_DW-1:0] pwdata,
  output logic [bmprle_pkg::CFG_DW-1:0] prdata,
  output logic                          pready
);

  // configuration registers
  logic        mode_q;
  logic [14:0] width_q;
  logic [14:0] height_q;
  logic [13:0] start_row_q;
  logic        descend_q;

  // parse state
  bmprle_pkg::phase_e phase_q, phase_d;
  bmprle_pkg::byte_t  count_q, count_d;
  bmprle_pkg::byte_t  delta_x_q, delta_x_d;
  bmprle_pkg::byte_t  abs_left_q, abs_left_d;
  logic               pad_q, pad_d;
  bmprle_pkg::row_t   row_q, row_d;
  bmprle_pkg::col_t   col_q, col_d;
  logic               sat_q, sat_d;

  // result register
  logic                  out_valid_q, out_valid_d;
  bmprle_pkg::span_row_t out_row_q;
  bmprle_pkg::span_col_t out_col_q;
  bmprle_pkg::byte_t     out_len_q, out_len_d;
  bmprle_pkg::byte_t     out_c1_q, out_c1_d;
  bmprle_pkg::byte_t     out_c2_q, out_c2_d;
  logic                  out_oob_q, out_oob_d;
  logic                  out_eoi_q, out_eoi_d;

  logic                         cfg_wr;
  bmprle_pkg::reg_idx_e         cfg_idx;
  logic                         restart_w;
  logic                         start_sat;
  logic                         in_fire;
  logic                         emit;
  bmprle_pkg::byte_t            b;
  bmprle_pkg::byte_t            col_add;
  bmprle_pkg::byte_t            row_mag;
  bmprle_pkg::byte_t            abs_len;
  bmprle_pkg::rowx_t            row_mag_ext;
  bmprle_pkg::rowx_t            row_sum;
  bmprle_pkg::colx_t            col_sum;
  bmprle_pkg::row_t             row_clamp;
  bmprle_pkg::col_t             col_clamp;
  logic                         row_sat;
  logic                         col_sat;
  logic                         oob_now;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign cfg_idx   = bmprle_pkg::reg_idx_e'(paddr[4:2]);
  assign restart_w = cfg_wr && (cfg_idx == bmprle_pkg::REG_START_ROW);
  assign start_sat = 32'(pwdata[13:0]) > 32'(bmprle_pkg::ROW_HI);

  always_comb begin
    case (cfg_idx)
      bmprle_pkg::REG_MODE:      prdata = 32'(mode_q);
      bmprle_pkg::REG_WIDTH:     prdata = 32'(width_q);
      bmprle_pkg::REG_HEIGHT:    prdata = 32'(height_q);
      bmprle_pkg::REG_START_ROW: prdata = 32'(start_row_q);
      bmprle_pkg::REG_DESCEND:   prdata = 32'(descend_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      width_q     <= 15'd1;
      height_q    <= 15'd1;
      start_row_q <= 14'd0;
      descend_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bmprle_pkg::REG_MODE:      mode_q      <= pwdata[0];
        bmprle_pkg::REG_WIDTH:     width_q     <= pwdata[14:0];
        bmprle_pkg::REG_HEIGHT:    height_q    <= pwdata[14:0];
        bmprle_pkg::REG_START_ROW: start_row_q <= pwdata[13:0];
        bmprle_pkg::REG_DESCEND:   descend_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Coordinate arithmetic: one row adder and one column adder
  // --------------------------------------------------------------------------
  assign in_fire     = data_i.valid && data_i.ready;
  assign data_i.ready = !out_valid_q || span_o.ready;
  assign b           = data_i.data_byte;
  assign abs_len     = (mode_q && (abs_left_q >= 8'd2)) ? 8'd2 : 8'd1;

  always_comb begin
    case (phase_q)
      bmprle_pkg::PH_SECOND:  col_add = count_q;
      bmprle_pkg::PH_DELTA_Y: col_add = delta_x_q;
      bmprle_pkg::PH_ABS:     col_add = abs_len;
      default:                col_add = 8'd0;
    endcase
    row_mag = (phase_q == bmprle_pkg::PH_DELTA_Y) ? b : 8'd1;
  end

  assign row_mag_ext = {{(bmprle_pkg::ROW_EXT_W-8){1'b0}}, row_mag};
  assign row_sum     = bmprle_pkg::ROW_EXT_W'(row_q) + (descend_q ? -row_mag_ext : row_mag_ext);
  assign col_sum     = {1'b0, col_q} + bmprle_pkg::COL_EXT_W'(col_add);

  always_comb begin
    row_sat   = 1'b0;
    row_clamp = row_sum[bmprle_pkg::COORD_BITS-1:0];
    if (row_sum > bmprle_pkg::ROW_HI) begin
      row_sat   = 1'b1;
      row_clamp = bmprle_pkg::ROW_HI[bmprle_pkg::COORD_BITS-1:0];
    end else if (row_sum < bmprle_pkg::ROW_LO) begin
      row_sat   = 1'b1;
      row_clamp = bmprle_pkg::ROW_LO[bmprle_pkg::COORD_BITS-1:0];
    end
    col_sat   = col_sum > bmprle_pkg::COL_HI;
    col_clamp = col_sat ? bmprle_pkg::COL_HI[bmprle_pkg::COORD_BITS-1:0]
                        : col_sum[bmprle_pkg::COORD_BITS-1:0];
  end

  // col_sum already holds column plus span length whenever a span is emitted
  assign oob_now = sat_q || row_q[bmprle_pkg::COORD_BITS-1] ||
                   (32'(row_q[bmprle_pkg::COORD_BITS-1:0]) >= 32'(height_q)) ||
                   (32'(col_sum) > 32'(width_q));

  // --------------------------------------------------------------------------
  // Parser
  // --------------------------------------------------------------------------
  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    delta_x_d  = delta_x_q;
    abs_left_d = abs_left_q;
    pad_d      = pad_q;
    row_d      = row_q;
    col_d      = col_q;
    sat_d      = sat_q;
    emit       = 1'b0;
    out_len_d  = 8'd0;
    out_c1_d   = 8'd0;
    out_c2_d   = 8'd0;
    out_eoi_d  = 1'b0;
    out_oob_d  = oob_now;

    case (phase_q)
      bmprle_pkg::PH_COUNT: begin
        count_d = b;
        phase_d = bmprle_pkg::PH_SECOND;
      end
      bmprle_pkg::PH_SECOND: begin
        phase_d = bmprle_pkg::PH_COUNT;
        if (count_q != 8'd0) begin
          emit      = 1'b1;
          out_len_d = count_q;
          out_c1_d  = mode_q ? {4'd0, b[7:4]} : b;
          out_c2_d  = mode_q ? {4'd0, b[3:0]} : b;
          col_d     = col_clamp;
          sat_d     = sat_q || col_sat;
        end else begin
          case (b)
            bmprle_pkg::ESC_EOL: begin
              col_d = '0;
              row_d = row_clamp;
              sat_d = sat_q || row_sat;
            end
            bmprle_pkg::ESC_EOB: begin
              emit      = 1'b1;
              out_eoi_d = 1'b1;
              phase_d   = bmprle_pkg::PH_DONE;
            end
            bmprle_pkg::ESC_DELTA: phase_d = bmprle_pkg::PH_DELTA_X;
            default: begin
              abs_left_d = b;
              // byte count is ceil(b/2) in RLE4, b in RLE8; pad when it is odd
              pad_d      = mode_q ? (b[1] ^ b[0]) : b[0];
              phase_d    = bmprle_pkg::PH_ABS;
            end
          endcase
        end
      end
      bmprle_pkg::PH_DELTA_X: begin
        delta_x_d = b;
        phase_d   = bmprle_pkg::PH_DELTA_Y;
      end
      bmprle_pkg::PH_DELTA_Y: begin
        col_d   = col_clamp;
        row_d   = row_clamp;
        sat_d   = sat_q || col_sat || row_sat;
        phase_d = bmprle_pkg::PH_COUNT;
      end
      bmprle_pkg::PH_ABS: begin
        if (abs_left_q == 8'd0) begin
          phase_d = bmprle_pkg::PH_COUNT;
        end else begin
          emit       = 1'b1;
          out_len_d  = abs_len;
          out_c1_d   = mode_q ? {4'd0, b[7:4]} : b;
          out_c2_d   = mode_q ? ((abs_len == 8'd2) ? {4'd0, b[3:0]} : 8'd0) : b;
          col_d      = col_clamp;
          sat_d      = sat_q || col_sat;
          abs_left_d = abs_left_q - abs_len;
          if (abs_left_q == abs_len) begin
            phase_d = pad_q ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_COUNT;
          end
        end
      end
      bmprle_pkg::PH_PAD: begin
        pad_d   = 1'b0;
        phase_d = bmprle_pkg::PH_COUNT;
      end
      bmprle_pkg::PH_DONE: ;
      default: phase_d = bmprle_pkg::PH_COUNT;
    endcase
  end

  assign out_valid_d = (in_fire && emit) || (out_valid_q && !span_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= bmprle_pkg::PH_COUNT;
      count_q     <= 8'd0;
      delta_x_q   <= 8'd0;
      abs_left_q  <= 8'd0;
      pad_q       <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (restart_w) begin
        phase_q    <= bmprle_pkg::PH_COUNT;
        count_q    <= 8'd0;
        delta_x_q  <= 8'd0;
        abs_left_q <= 8'd0;
        pad_q      <= 1'b0;
        col_q      <= '0;
        sat_q      <= start_sat;
        row_q      <= start_sat ? bmprle_pkg::ROW_HI[bmprle_pkg::COORD_BITS-1:0]
                                : bmprle_pkg::COORD_BITS'(pwdata[13:0]);
      end else if (in_fire) begin
        phase_q    <= phase_d;
        count_q    <= count_d;
        delta_x_q  <= delta_x_d;
        abs_left_q <= abs_left_d;
        pad_q      <= pad_d;
        row_q      <= row_d;
        col_q      <= col_d;
        sat_q      <= sat_d;
      end
    end
  end

  // load the result payload only on a beat that produces a span
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_row_q <= bmprle_pkg::SPAN_W'(row_q);
      out_col_q <= bmprle_pkg::SPAN_W'(col_q);
      out_len_q <= out_len_d;
      out_c1_q  <= out_c1_d;
      out_c2_q  <= out_c2_d;
      out_oob_q <= out_oob_d;
      out_eoi_q <= out_eoi_d;
    end
  end

  assign span_o.valid         = out_valid_q;
  assign span_o.span_row      = out_row_q;
  assign span_o.span_col      = out_col_q;
  assign span_o.span_length   = out_len_q;
  assign span_o.color_first   = out_c1_q;
  assign span_o.color_second  = out_c2_q;
  assign span_o.out_of_bounds = out_oob_q;
  assign span_o.end_of_image  = out_eoi_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BMPRLE_ASSERT(a_eoi_empty, clk_i, rst_ni, (out_valid_q && out_eoi_q) |-> (out_len_q == 8'd0))
  `BMPRLE_ASSERT(a_abs_nonzero, clk_i, rst_ni, (phase_q == bmprle_pkg::PH_ABS) |-> (abs_left_q != 8'd0))
  `BMPRLE_ASSERT_NEXT(a_done_sticky, clk_i, rst_ni, (phase_q == bmprle_pkg::PH_DONE) && !restart_w, phase_q == bmprle_pkg::PH_DONE)
  `BMPRLE_ASSERT_NEXT(a_span_loaded, clk_i, rst_ni, in_fire && emit, out_valid_q)

endmodule

### verif/bmprle_span_sb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BMP RLE span scoreboard
// Follows the decoder's parse state byte by byte, queues the spans each
// accepted byte should produce and checks every span taken from the result
// channel against the oldest queued span, field by field.
// ----------------------------------------------------------------------------
package bmprle_span_sb_pkg;
  import bmprle_pkg::*;

  localparam longint ROW_TOP    = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint ROW_BOTTOM = -(longint'(1) << (COORD_BITS - 1));
  localparam longint COL_TOP    = (longint'(1) << COORD_BITS) - 1;

  typedef struct {
    span_row_t row;
    span_col_t col;
    byte_t     length;
    byte_t     color_a;
    byte_t     color_b;
    logic      oob;
    logic      eoi;
  } span_t;

  class span_scoreboard;
    bit        rle4;
    bit [14:0] width;
    bit [14:0] height;
    bit [13:0] first_row;
    bit        descend;

    phase_e    phase;
    byte_t     lead_count;
    byte_t     skip_x;
    byte_t     abs_left;
    bit        pad_due;
    longint    row;
    longint    col;
    bit        clamped;

    span_t     span_q[$];
    int        errors;

    function new();
      errors    = 0;
      rle4      = 1'b0;
      width     = 15'd1;
      height    = 15'd1;
      first_row = 14'd0;
      descend   = 1'b0;
      restart();
    endfunction

    function void restart();
      phase      = PH_COUNT;
      lead_count = 8'h00;
      skip_x     = 8'h00;
      abs_left   = 8'h00;
      pad_due    = 1'b0;
      clamped    = 1'b0;
      set_row(longint'(first_row));
      col        = 0;
    endfunction

    function void set_row(longint v);
      if (v > ROW_TOP) begin
        v = ROW_TOP;
        clamped = 1'b1;
      end
      if (v < ROW_BOTTOM) begin
        v = ROW_BOTTOM;
        clamped = 1'b1;
      end
      row = v;
    endfunction

    function void set_col(longint v);
      if (v > COL_TOP) begin
        v = COL_TOP;
        clamped = 1'b1;
      end
      if (v < 0) begin
        v = 0;
        clamped = 1'b1;
      end
      col = v;
    endfunction

    function longint row_step();
      return descend ? -1 : 1;
    endfunction

    function void add_span(int len, byte_t a, byte_t b, bit eoi);
      span_t s;
      s.row     = span_row_t'(row);
      s.col     = span_col_t'(col);
      s.length  = byte_t'(len);
      s.color_a = a;
      s.color_b = b;
      s.oob     = clamped || row < 0 || row >= longint'(height) ||
                  col + longint'(len) > longint'(width);
      s.eoi     = eoi;
      span_q.push_back(s);
    endfunction

    function void write_reg(int idx, int unsigned val);
      case (idx)
        REG_MODE:      rle4 = val[0];
        REG_WIDTH:     width = val[14:0];
        REG_HEIGHT:    height = val[14:0];
        REG_START_ROW: begin
          first_row = val[13:0];
          restart();
        end
        REG_DESCEND:   descend = val[0];
        default: ;
      endcase
    endfunction

    function void note_byte(byte_t b);
      int nbytes;
      int len;
      case (phase)
        PH_COUNT: begin
          lead_count = b;
          phase = PH_SECOND;
        end
        PH_SECOND: begin
          phase = PH_COUNT;
          if (lead_count != 8'h00) begin
            if (rle4) begin
              add_span(int'(lead_count), b >> 4, b & 8'h0f, 1'b0);
            end else begin
              add_span(int'(lead_count), b, b, 1'b0);
            end
            set_col(col + longint'(lead_count));
          end else if (b == ESC_EOL) begin
            col = 0;
            set_row(row + row_step());
          end else if (b == ESC_EOB) begin
            add_span(0, 8'h00, 8'h00, 1'b1);
            phase = PH_DONE;
          end else if (b == ESC_DELTA) begin
            phase = PH_DELTA_X;
          end else begin
            // pad count is fixed by the mode at the start of the block
            abs_left = b;
            nbytes = rle4 ? (int'(b) + 1) / 2 : int'(b);
            pad_due = nbytes[0];
            phase = PH_ABS;
          end
        end
        PH_DELTA_X: begin
          skip_x = b;
          phase = PH_DELTA_Y;
        end
        PH_DELTA_Y: begin
          set_col(col + longint'(skip_x));
          set_row(row + row_step() * longint'(b));
          phase = PH_COUNT;
        end
        PH_ABS: begin
          if (abs_left == 8'h00) begin
            phase = PH_COUNT;
          end else begin
            len = (rle4 && abs_left >= 8'd2) ? 2 : 1;
            if (rle4) begin
              add_span(len, b >> 4, (len == 2) ? (b & 8'h0f) : 8'h00, 1'b0);
            end else begin
              add_span(1, b, b, 1'b0);
            end
            set_col(col + longint'(len));
            abs_left = abs_left - byte_t'(len);
            if (abs_left == 8'h00) phase = pad_due ? PH_PAD : PH_COUNT;
          end
        end
        PH_PAD: begin
          pad_due = 1'b0;
          phase = PH_COUNT;
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return span_q.size();
    endfunction

    task report(string what);
      $display("%0t: span mismatch: %s", $time, what);
      errors++;
    endtask

    task check_span(span_t got);
      span_t want;
      if (span_q.size() == 0) begin
        report($sformatf("unexpected span row %0d col %0d len %0d",
                         got.row, got.col, got.length));
        return;
      end
      want = span_q.pop_front();
      if (got.row !== want.row)
        report($sformatf("span_row %0d, want %0d", got.row, want.row));
      if (got.col !== want.col)
        report($sformatf("span_col %0d, want %0d", got.col, want.col));
      if (got.length !== want.length)
        report($sformatf("span_length %0d, want %0d", got.length, want.length));
      if (got.color_a !== want.color_a)
        report($sformatf("color_first %0h, want %0h", got.color_a, want.color_a));
      if (got.color_b !== want.color_b)
        report($sformatf("color_second %0h, want %0h", got.color_b, want.color_b));
      if (got.oob !== want.oob)
        report($sformatf("out_of_bounds %b, want %b", got.oob, want.oob));
      if (got.eoi !== want.eoi)
        report($sformatf("end_of_image %b, want %b", got.eoi, want.eoi));
    endtask

    task check_drained();
      if (span_q.size() != 0)
        report($sformatf("%0d spans never arrived", span_q.size()));
    endtask
  endclass

endpackage

### verif/bmp_rle_pixel_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BMP RLE pixel decoder testbench
// Feeds RLE8/RLE4 byte streams through the byte channel with random gaps,
// stalls the span channel at random, reprograms the registers between
// bursts and checks every span against a scoreboard that tracks the parser.
// ----------------------------------------------------------------------------
module bmp_rle_pixel_decoder_tb;
  import bmprle_pkg::*;
  import bmprle_span_sb_pkg::*;

  localparam int     ITEM_TARGET  = 2000;
  localparam int     DRAIN_CYCLES = 3;
  localparam int     REG_SPARE_LO = 5;
  localparam int     REG_SPARE_HI = 7;
  localparam byte_t  ABS_MIN      = 8'd3;
  localparam longint TIMEOUT_NS   = 20_000_000;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  bmprle_in_if  in_ch ();
  bmprle_out_if span_ch ();

  span_scoreboard sb;
  span_t          seen_span;
  int             items_sent = 0;
  int             hold_left = 0;
  bit             calm = 1'b0;
  bit             need_restart = 1'b0;

  bmp_rle_pixel_decoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .data_i  (in_ch),
    .span_o  (span_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // span sink: random stalls
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      span_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      span_ch.ready <= 1'b1;
      hold_left <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && span_ch.valid && span_ch.ready) begin
      seen_span.row     = span_ch.span_row;
      seen_span.col     = span_ch.span_col;
      seen_span.length  = span_ch.span_length;
      seen_span.color_a = span_ch.color_first;
      seen_span.color_b = span_ch.color_second;
      seen_span.oob     = span_ch.out_of_bounds;
      seen_span.eoi     = span_ch.end_of_image;
      sb.check_span(seen_span);
    end
  end

  task automatic cfg_write(input int idx, input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_byte(input byte_t value);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= value;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    // bytes after the end marker are dropped by the block
    if (sb.phase != PH_DONE) items_sent++;
    sb.note_byte(value);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_run(input byte_t n, input byte_t color);
    send_byte(n);
    send_byte(color);
  endtask

  task automatic send_escape(input byte_t code);
    send_byte(8'h00);
    send_byte(code);
  endtask

  task automatic send_delta(input byte_t dx, input byte_t dy);
    send_escape(ESC_DELTA);
    send_byte(dx);
    send_byte(dy);
  endtask

  // cut stops the block short and skips the pad
  task automatic send_absolute(input byte_t n, input bit cut);
    int nbytes;
    int sent;
    nbytes = sb.rle4 ? (int'(n) + 1) / 2 : int'(n);
    sent = cut ? $urandom_range(0, nbytes - 1) : nbytes;
    send_escape(n);
    repeat (sent) send_byte(byte_t'($urandom));
    if (!cut && nbytes[0]) send_byte(byte_t'($urandom));
  endtask

  function automatic byte_t pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'd255;
    if (r < 16) return 8'd1;
    return byte_t'($urandom_range(2, 24));
  endfunction

  function automatic byte_t pick_abs_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 8'd255;
    if (r < 12) return ABS_MIN;
    return byte_t'($urandom_range(ABS_MIN, 16));
  endfunction

  function automatic int unsigned pick_extent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 1;
    if (r < 30) return 16384;
    if (r < 75) return $urandom_range(1, 64);
    return $urandom_range(1, 16384);
  endfunction

  function automatic int unsigned pick_row();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 30) return 16383;
    if (r < 80) return $urandom_range(0, 8);
    return $urandom_range(0, 16383);
  endfunction

  task automatic random_token();
    int    r;
    byte_t dx;
    byte_t dy;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_run(pick_count(), byte_t'($urandom));
    end else if (r < 65) begin
      send_absolute(pick_abs_len(), 1'b0);
    end else if (r < 77) begin
      send_escape(ESC_EOL);
    end else if (r < 93) begin
      r = $urandom_range(0, 99);
      dx = (r < 10) ? 8'd255 : (r < 20) ? 8'd0 : byte_t'($urandom_range(0, 20));
      dy = ($urandom_range(0, 9) == 0) ? 8'd255 : byte_t'($urandom_range(0, 3));
      send_delta(dx, dy);
    end else begin
      send_escape(ESC_EOB);
    end
  endtask

  task automatic shuffle_config();
    if ($urandom_range(0, 2) == 0) cfg_write(REG_MODE, $urandom_range(0, 1));
    if ($urandom_range(0, 2) == 0) cfg_write(REG_WIDTH, pick_extent());
    if ($urandom_range(0, 2) == 0) cfg_write(REG_HEIGHT, pick_extent());
    if ($urandom_range(0, 3) == 0) cfg_write(REG_DESCEND, $urandom_range(0, 1));
    if (need_restart || $urandom_range(0, 3) == 0) cfg_write(REG_START_ROW, pick_row());
    if ($urandom_range(0, 19) == 0)
      cfg_write($urandom_range(REG_SPARE_LO, REG_SPARE_HI), $urandom);
    need_restart = 1'b0;
  endtask

  // push the coordinates into their clamps: rows by repeated deltas, columns (descending pass) by deltas and long runs
  task automatic drift(input bit desc);
    cfg_write(REG_DESCEND, desc);
    cfg_write(REG_WIDTH, 16384);
    cfg_write(REG_HEIGHT, 16384);
    cfg_write(REG_START_ROW, desc ? 0 : 16383);
    repeat (desc ? 131 : 66) begin
      send_delta(8'd255, 8'd255);
      if (desc) send_run(8'd255, byte_t'($urandom));
    end
    send_run(pick_count(), byte_t'($urandom));
    send_escape(ESC_EOL);
    send_run(pick_count(), byte_t'($urandom));
    wait_drained();
  endtask

  initial begin
    int kind;
    int drifts;
    sb = new();
    drifts = 0;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    span_ch.ready   = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_write(REG_MODE, 0);
    cfg_write(REG_WIDTH, 8);
    cfg_write(REG_HEIGHT, 4);
    cfg_write(REG_DESCEND, 0);
    cfg_write(REG_START_ROW, 0);
    cfg_write(REG_SPARE_LO, 32'h0000_0001);
    send_run(8'd255, 8'hff);
    send_escape(ESC_EOL);
    send_delta(8'd5, 8'd3);
    wait_drained();
    cfg_write(REG_MODE, 1);
    send_run(8'd4, 8'ha5);
    // odd pixel count: the last byte carries a single pixel
    send_escape(ABS_MIN);
    send_byte(8'h12);
    send_byte(8'h30);
    // switch to RLE8 in the middle of an RLE4 block
    send_escape(8'd5);
    send_byte(8'hc7);
    wait_drained();
    cfg_write(REG_MODE, 0);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(byte_t'($urandom));
    send_byte(8'h00);
    send_escape(ESC_EOB);
    send_byte(8'h00);
    send_byte(8'h01);
    wait_drained();
    need_restart = 1'b1;

    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      shuffle_config();
      if ((drifts == 0 && items_sent >= 400) || (drifts == 1 && items_sent >= 1200)) begin
        drift(drifts == 0);
        drifts++;
      end
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        repeat ($urandom_range(4, 30)) begin
          if (sb.phase != PH_DONE) random_token();
        end
      end else if (kind < 88) begin
        repeat ($urandom_range(3, 20)) send_byte(byte_t'($urandom));
        need_restart = 1'b1;
      end else begin
        repeat ($urandom_range(0, 4)) random_token();
        if ($urandom_range(0, 1) == 1) begin
          send_absolute(pick_abs_len(), 1'b1);
        end else begin
          send_escape(ESC_DELTA);
          send_byte(byte_t'($urandom));
        end
        need_restart = 1'b1;
      end
      if (sb.phase == PH_DONE) begin
        repeat ($urandom_range(0, 3)) send_byte(byte_t'($urandom));
        need_restart = 1'b1;
      end
      wait_drained();
    end

    wait_drained();
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
